[rtl/core/bse_pkg.sv]
// Shared sizes, opcodes, status codes and result layout for the bounded stack engine.
package bse_pkg;

  localparam int DEPTH    = 16;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int WORD_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;
  localparam int M_DATA_W = WORD_W + 1 + STAT_W + OCC_W;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH  = 3'd3;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd4;
  localparam logic [OP_W-1:0] OP_MIN     = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  // First member sits in the highest bits, so result_value lands at bit 0.
  typedef struct packed {
    logic [OCC_W-1:0]  occupancy;
    logic [STAT_W-1:0] status;
    logic              found;
    logic [WORD_W-1:0] result_value;
  } result_t;

endpackage

[rtl/core/bse_ram.sv]
// Simple dual-read, single-write RAM with registered read data.
module bse_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] ra_addr,
  input  logic [ADDR_W-1:0] rb_addr,
  output logic [WIDTH-1:0]  ra_data,
  output logic [WIDTH-1:0]  rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

[rtl/core/bounded_stack_engine.sv]
// Bounded LIFO stack of signed 32-bit words, DEPTH entries, held in one RAM.
// One item is processed at a time and each item yields one result transfer.
// With a free output, push, an unused opcode, an empty stack and reverse of a
// single entry answer from IDLE; pop and peek pass through TOP_RD (one RAM
// read), search and minimum read the N stored entries in SCAN (one entry read
// per cycle), and reverse runs RV_SWAP then RV_WRHI per pair (each swap needs
// two writes through the single RAM write port). A result that cannot leave
// because the output is still occupied is parked, and input is held until it goes out.
module bounded_stack_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bse_pkg::WORD_W-1:0]   s_tdata,  // operand_value
  input  logic [bse_pkg::OP_W-1:0]     s_tuser,  // opcode
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [bse_pkg::M_DATA_W-1:0] m_tdata   // result_value, found, status, occupancy
);

  import bse_pkg::*;

  typedef enum logic [2:0] {IDLE, TOP_RD, SCAN, RV_SWAP, RV_WRHI, HOLD} state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  idx;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [OP_W-1:0]   op_q;
  logic [WORD_W-1:0] key;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] tmp;
  logic              hit;
  result_t           out_q;
  result_t           pend;
  result_t           fin;
  logic              fin_valid;

  logic              acc_in;
  logic              out_free;
  logic              out_load;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] ra_addr;
  logic [ADDR_W-1:0] rb_addr;
  logic [WORD_W-1:0] ra_data;
  logic [WORD_W-1:0] rb_data;
  logic              hit_now;
  logic [WORD_W-1:0] min_now;
  logic              more_pairs;

  assign acc_in   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (fin_valid || state == HOLD);
  assign s_tready = (state == IDLE);
  assign m_tdata  = out_q;

  // Data arriving in SCAN belongs to entry idx-1; entry 0 seeds the minimum.
  assign hit_now    = hit || (ra_data == key);
  assign min_now    = ((idx == CNT_W'(1)) || ($signed(ra_data) < $signed(acc))) ? ra_data : acc;
  assign more_pairs = ({1'b0, lo} + (ADDR_W + 1)'(2)) < {1'b0, hi};

  bse_ram #(
    .DEPTH  (DEPTH),
    .WIDTH  (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  // No read whose data is used shares its entry with a write in the same cycle,
  // so no bypass.
  always_comb begin
    count_next = count;
    we         = 1'b0;
    waddr      = lo;
    wdata      = rb_data;
    ra_addr    = lo;
    rb_addr    = hi;
    fin_valid  = 1'b0;
    fin        = '0;
    unique case (state)
      IDLE: begin
        if (acc_in) begin
          unique case (s_tuser)
            OP_PUSH: begin
              fin_valid = 1'b1;
              if (count < CNT_W'(DEPTH)) begin
                we         = 1'b1;
                waddr      = count[ADDR_W-1:0];
                wdata      = s_tdata;
                count_next = count + CNT_W'(1);
              end else begin
                fin.status = ST_FULL;
              end
            end
            OP_POP, OP_PEEK: begin
              if (count == '0) begin
                fin_valid        = 1'b1;
                fin.result_value = EMPTY_WORD;
                fin.status       = ST_EMPTY;
              end else begin
                ra_addr = ADDR_W'(count - CNT_W'(1));
                if (s_tuser == OP_POP) begin
                  count_next = count - CNT_W'(1);
                end
              end
            end
            OP_SEARCH, OP_MIN: begin
              ra_addr = '0;
              if (count == '0) begin
                fin_valid = 1'b1;
                if (s_tuser == OP_MIN) begin
                  fin.result_value = EMPTY_WORD;
                  fin.status       = ST_EMPTY;
                end
              end
            end
            OP_REVERSE: begin
              ra_addr = '0;
              rb_addr = ADDR_W'(count - CNT_W'(1));
              if (count <= CNT_W'(1)) begin
                fin_valid = 1'b1;
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      TOP_RD: begin
        fin_valid        = 1'b1;
        fin.result_value = ra_data;
      end
      SCAN: begin
        ra_addr = idx[ADDR_W-1:0];
        if (idx == count) begin
          fin_valid = 1'b1;
          if (op_q == OP_SEARCH) begin
            fin.found = hit_now;
          end else begin
            fin.result_value = min_now;
          end
        end
      end
      RV_SWAP: begin
        we    = 1'b1;
        waddr = lo;
        wdata = rb_data;
      end
      RV_WRHI: begin
        we      = 1'b1;
        waddr   = hi;
        wdata   = tmp;
        ra_addr = lo + ADDR_W'(1);
        rb_addr = hi - ADDR_W'(1);
        if (!more_pairs) begin
          fin_valid = 1'b1;
        end
      end
      HOLD: begin
      end
      default: begin
      end
    endcase
    fin.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      // Drop valid once taken, unless a new result loads in the same cycle.
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      if (fin_valid) begin
        if (out_free) begin
          out_q    <= fin;
          m_tvalid <= 1'b1;
          state    <= IDLE;
        end else begin
          pend  <= fin;
          state <= HOLD;
        end
      end else begin
        unique case (state)
          IDLE: begin
            if (acc_in) begin
              op_q <= s_tuser;
              key  <= s_tdata;
              hit  <= 1'b0;
              idx  <= CNT_W'(1);
              lo   <= '0;
              hi   <= ADDR_W'(count - CNT_W'(1));
              priority if (s_tuser == OP_POP || s_tuser == OP_PEEK) begin
                state <= TOP_RD;
              end else if (s_tuser == OP_REVERSE) begin
                state <= RV_SWAP;
              end else begin
                state <= SCAN;
              end
            end
          end
          SCAN: begin
            idx <= idx + CNT_W'(1);
            hit <= hit_now;
            acc <= min_now;
          end
          RV_SWAP: begin
            tmp   <= ra_data;
            state <= RV_WRHI;
          end
          RV_WRHI: begin
            lo    <= lo + ADDR_W'(1);
            hi    <= hi - ADDR_W'(1);
            state <= RV_SWAP;
          end
          HOLD: begin
            if (out_free) begin
              out_q    <= pend;
              m_tvalid <= 1'b1;
              state    <= IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  ap_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stack count beyond depth");

  ap_full_push: assert property (@(posedge clk) disable iff (rst)
    acc_in && s_tuser == OP_PUSH && count == CNT_W'(DEPTH) |=> count == CNT_W'(DEPTH))
    else $error("push on full stack changed count");

  ap_pop_dec: assert property (@(posedge clk) disable iff (rst)
    acc_in && s_tuser == OP_POP && count != '0 |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not drop one entry");

  ap_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN || state == RV_SWAP || state == RV_WRHI) |=> count == $past(count))
    else $error("count moved during a walk");

  ap_hold_busy: assert property (@(posedge clk) disable iff (rst)
    state == HOLD |-> m_tvalid)
    else $error("result parked while output free");
`endif

endmodule
